### rtl/neighbor_color_similarity_mask_macros.svh
// Assertion macros for the neighbor color similarity mask block.
// Expects aclk and aresetn in the scope of each use.
`ifndef NEIGHBOR_COLOR_SIMILARITY_MASK_MACROS_SVH
`define NEIGHBOR_COLOR_SIMILARITY_MASK_MACROS_SVH

// Same-cycle implication, checked outside reset
`define NCSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("neighbor mask check failed");

// Next-cycle implication, checked outside reset
`define NCSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("neighbor mask check failed");

`endif

### rtl/ncsm_pkg.sv
// Shared types, sizes and the color distance function of the neighbor mask block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ncsm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 11;
    localparam int POS_W      = 10;
    localparam int THR_W      = 18;
    localparam int PIX_W      = 24;
    localparam int MASK_W     = 8;
    localparam int CHAN_W     = 8;

    typedef logic [PIX_W-1:0]   pixel_t;
    // One window column: [0] upper row, [1] middle row, [2] newest row
    typedef pixel_t [2:0]       column_t;
    // Line store entry: upper line in the high half, middle line in the low half
    typedef logic [2*PIX_W-1:0] line_entry_t;

    // Which neighbor directions lie inside the frame
    typedef struct packed {
        logic top_ok;
        logic bottom_ok;
        logic left_ok;
        logic right_ok;
    } edge_t;

    // Squared RGB distance; three 8x8 squares fit in 18 bits
    function automatic logic [THR_W-1:0] dist_sq(pixel_t a, pixel_t b);
        logic [CHAN_W-1:0]   ca;
        logic [CHAN_W-1:0]   cb;
        logic [CHAN_W-1:0]   d;
        logic [2*CHAN_W-1:0] sq;
        logic [THR_W-1:0]    sum;
        sum = '0;
        for (int s = 0; s < 3; s++) begin
            ca  = a[s*CHAN_W +: CHAN_W];
            cb  = b[s*CHAN_W +: CHAN_W];
            d   = (ca > cb) ? (ca - cb) : (cb - ca);
            sq  = (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
            sum = sum + THR_W'(sq);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

### rtl/neighbor_color_similarity_mask.sv
// 3x3 neighbor color similarity mask over a raster stream of 24-bit RGB pixels.
// Depends on ncsm_pkg, ncsm_line_mem, ncsm_mask_calc and the assertion macro header.
//
// Takes one item per clock and returns at most one mask per item, sustained at one item
// per cycle unless a mask in stage one waits on a full output register. The item that
// completes a window passes stage one with the registered line store read, then the
// distance compares into the output register. A pixel's mask is completed by the pixel
// one row plus one column later, so after the last pixel of a frame the user sends
// frame_width + 1 further items (flush, or pixels, whose values are dropped) to drain
// the last row; flush items sent while pixels of the frame are still expected are taken
// and ignored. Writing frame_width or frame_height restarts the frame; the threshold
// applies to the next mask. Widths or heights (low 11 bits) of 0 act as 1, above 1024 as
// 1024. The line store RAM is not cleared after reset: entries not yet written for the
// current frame only feed neighbors outside the frame, whose mask bits are always clear.
`timescale 1ns / 1ps
`default_nettype none

module neighbor_color_similarity_mask
    import ncsm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration write port
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [THR_W-1:0]  cfg_wdata,
    // Pixel input
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  s_tdata,   // [23:0] pixel_color
    input  wire logic              s_tuser,   // flush
    // Mask output
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // [7:0] neighbor_mask, [17:8] center_x,
                                              // [27:18] center_y, [31:28] zero
    output logic                   m_tlast    // last_of_frame
);

    `include "neighbor_color_similarity_mask_macros.svh"

    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_DIST_THRESHOLD = 2'd2;

    localparam logic [DIM_W-1:0] RST_WIDTH     = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_HEIGHT    = DIM_W'(480);
    localparam logic [THR_W-1:0] RST_THRESHOLD = THR_W'(2500);

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                   logic [DIM_W-1:0] vmax);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > vmax) begin
            return vmax;
        end else begin
            return v;
        end
    endfunction

    // Configuration
    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              cfg_restart;

    // Frame counters
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  ox_reg, ox_next;
    logic [POS_W-1:0]  oy_reg, oy_next;

    // Input stage decode
    logic              s_accept;
    logic              restart_a;
    logic [ADDR_W-1:0] c_a;
    logic [ROW_W-1:0]  r_a;
    logic [POS_W-1:0]  ox_a;
    logic [POS_W-1:0]  oy_a;
    logic              in_frame_a;
    logic              ignore_a;
    logic              live_a;
    pixel_t            pix_a;
    logic              emit_a;
    logic              last_a;
    logic [DIM_W-1:0]  col_inc_a;
    logic              col_wrap_a;
    edge_t             edge_a;

    // First pipeline stage
    logic              s1_valid_reg;
    pixel_t            s1_pix_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [POS_W-1:0]  s1_x_reg;
    logic [POS_W-1:0]  s1_y_reg;
    edge_t             s1_edge_reg;
    logic              s1_fwd_reg;
    line_entry_t       fwd_data_reg;
    logic              s1_adv;

    // Line store
    line_entry_t       mem_rdata;
    line_entry_t       mem_wdata;
    line_entry_t       entry_s1;
    column_t           new_col;

    // Window and result
    column_t           col_a_reg;
    column_t           col_b_reg;
    logic [MASK_W-1:0] mask_s1;
    logic              m_valid_reg, m_valid_next;
    logic [MASK_W-1:0] m_mask_reg;
    logic [POS_W-1:0]  m_x_reg;
    logic [POS_W-1:0]  m_y_reg;
    logic              m_last_reg;

    // Hold the configuration registers
    assign cfg_restart = cfg_we &&
                         (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg   <= RST_WIDTH;
            h_reg   <= RST_HEIGHT;
            thr_reg <= RST_THRESHOLD;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:    w_reg   <= clamp_dim(cfg_wdata[DIM_W-1:0],
                                                         DIM_W'(MAX_WIDTH));
                REG_FRAME_HEIGHT:   h_reg   <= clamp_dim(cfg_wdata[DIM_W-1:0],
                                                         DIM_W'(MAX_HEIGHT));
                REG_DIST_THRESHOLD: thr_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Decode the incoming transfer against the frame position
    assign s_accept   = s_tvalid && s_tready;
    assign restart_a  = (DIM_W'(col_reg) >= w_reg) ||
                        ((ROW_W+1)'(row_reg) > ((ROW_W+1)'(h_reg) + (ROW_W+1)'(1)));
    assign c_a        = restart_a ? '0 : col_reg;
    assign r_a        = restart_a ? '0 : row_reg;
    assign ox_a       = restart_a ? '0 : ox_reg;
    assign oy_a       = restart_a ? '0 : oy_reg;
    assign in_frame_a = r_a < ROW_W'(h_reg);
    assign ignore_a   = in_frame_a && s_tuser;
    assign live_a     = s_accept && !ignore_a;
    assign pix_a      = in_frame_a ? s_tdata : '0;
    assign emit_a     = (r_a >= ROW_W'(2)) || ((r_a == ROW_W'(1)) && (c_a != '0));
    assign last_a     = (DIM_W'(ox_a) == (w_reg - DIM_W'(1))) &&
                        (DIM_W'(oy_a) == (h_reg - DIM_W'(1)));
    assign col_inc_a  = DIM_W'(c_a) + DIM_W'(1);
    assign col_wrap_a = col_inc_a >= w_reg;

    assign edge_a.top_ok    = oy_a != '0;
    assign edge_a.bottom_ok = (DIM_W'(oy_a) + DIM_W'(1)) < h_reg;
    assign edge_a.left_ok   = ox_a != '0;
    assign edge_a.right_ok  = (DIM_W'(ox_a) + DIM_W'(1)) < w_reg;

    // Advance input and output positions
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        if (cfg_restart) begin
            col_next = '0;
            row_next = '0;
            ox_next  = '0;
            oy_next  = '0;
        end else if (s_accept) begin
            col_next = c_a;
            row_next = r_a;
            ox_next  = ox_a;
            oy_next  = oy_a;
            if (!ignore_a) begin
                if (emit_a && last_a) begin
                    col_next = '0;
                    row_next = '0;
                    ox_next  = '0;
                    oy_next  = '0;
                end else begin
                    if (col_wrap_a) begin
                        col_next = '0;
                        row_next = r_a + ROW_W'(1);
                    end else begin
                        col_next = col_inc_a[ADDR_W-1:0];
                    end
                    if (emit_a) begin
                        if ((DIM_W'(ox_a) + DIM_W'(1)) == w_reg) begin
                            ox_next = '0;
                            oy_next = oy_a + POS_W'(1);
                        end else begin
                            ox_next = ox_a + POS_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ox_reg  <= '0;
            oy_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
        end
    end

    // Stage one moves on unless its mask waits on a full output register
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_tready);
    assign s_tready = aresetn && (!s1_valid_reg || s1_adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (live_a) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Capture the item, and the line store write it must see when it hits the same column
    always_ff @(posedge aclk) begin
        if (live_a) begin
            s1_pix_reg   <= pix_a;
            s1_addr_reg  <= c_a;
            s1_emit_reg  <= emit_a;
            s1_last_reg  <= last_a;
            s1_x_reg     <= ox_a;
            s1_y_reg     <= oy_a;
            s1_edge_reg  <= edge_a;
            s1_fwd_reg   <= s1_adv && (s1_addr_reg == c_a);
            fwd_data_reg <= mem_wdata;
        end
    end

    // Shift the column down the two lines: old middle moves up, new pixel enters
    assign entry_s1   = s1_fwd_reg ? fwd_data_reg : mem_rdata;
    assign new_col[0] = entry_s1[2*PIX_W-1:PIX_W];
    assign new_col[1] = entry_s1[PIX_W-1:0];
    assign new_col[2] = s1_pix_reg;
    assign mem_wdata  = {new_col[1], new_col[2]};

    ncsm_line_mem u_line_mem (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata (mem_wdata),
        .re    (live_a),
        .raddr (c_a),
        .rdata (mem_rdata)
    );

    // Slide the window by one column per item
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            col_a_reg <= col_b_reg;
            col_b_reg <= new_col;
        end
    end

    ncsm_mask_calc u_mask_calc (
        .left_col   (col_a_reg),
        .center_col (col_b_reg),
        .right_col  (new_col),
        .edges      (s1_edge_reg),
        .threshold  (thr_reg),
        .mask       (mask_s1)
    );

    // Hold the result until the output transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv && s1_emit_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            m_mask_reg <= mask_s1;
            m_x_reg    <= s1_x_reg;
            m_y_reg    <= s1_y_reg;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_y_reg, m_x_reg, m_mask_reg};
    assign m_tlast  = m_last_reg;

    // An item without a mask never waits in stage one
    `NCSM_ASSERT_SAME(a_no_emit_never_stalls, s1_valid_reg && !s1_emit_reg, s1_adv)
    // A mask leaving stage one always lands in the output register
    `NCSM_ASSERT_NEXT(a_emit_reaches_output, s1_adv && s1_emit_reg, m_valid_reg)
    // The frame's final item brings every position counter back to the origin
    `NCSM_ASSERT_NEXT(a_frame_end_restarts, live_a && emit_a && last_a,
                      col_reg == '0 && row_reg == '0 && ox_reg == '0 && oy_reg == '0)

endmodule

`default_nettype wire

### rtl/ncsm_line_mem.sv
// Line store RAM: one write port, one read port with registered read data.
// Depends on ncsm_pkg for depth and entry type.
`timescale 1ns / 1ps
`default_nettype none

module ncsm_line_mem
    import ncsm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire line_entry_t       wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output line_entry_t            rdata
);

    line_entry_t mem [MAX_WIDTH];

    // Write, and read old contents on an address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/ncsm_mask_calc.sv
// Similarity mask of a 3x3 neighborhood: eight distance compares against the threshold.
// Depends on ncsm_pkg for the pixel types and dist_sq.
`timescale 1ns / 1ps
`default_nettype none

module ncsm_mask_calc
    import ncsm_pkg::*;
(
    input  wire column_t            left_col,
    input  wire column_t            center_col,
    input  wire column_t            right_col,
    input  wire edge_t              edges,
    input  wire logic [THR_W-1:0]   threshold,
    output logic [MASK_W-1:0]       mask
);

    pixel_t            nbr   [MASK_W];
    logic [MASK_W-1:0] in_ok;

    // Place neighbors in mask bit order, row by row, skipping the center
    always_comb begin
        nbr[0] = left_col[0];
        nbr[1] = center_col[0];
        nbr[2] = right_col[0];
        nbr[3] = left_col[1];
        nbr[4] = right_col[1];
        nbr[5] = left_col[2];
        nbr[6] = center_col[2];
        nbr[7] = right_col[2];

        in_ok[0] = edges.top_ok && edges.left_ok;
        in_ok[1] = edges.top_ok;
        in_ok[2] = edges.top_ok && edges.right_ok;
        in_ok[3] = edges.left_ok;
        in_ok[4] = edges.right_ok;
        in_ok[5] = edges.bottom_ok && edges.left_ok;
        in_ok[6] = edges.bottom_ok;
        in_ok[7] = edges.bottom_ok && edges.right_ok;
    end

    // Compare every neighbor against the center in parallel
    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            mask[i] = in_ok[i] && (dist_sq(center_col[1], nbr[i]) < threshold);
        end
    end

endmodule

`default_nettype wire
